// ===== rtl/oli_pkg.sv =====
package oli_pkg;

  localparam int VALUE_W  = 32;
  localparam int LENGTH_W = 5;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_PUSH_FRONT = 2'd0;
  localparam mode_t MODE_PUSH_BACK  = 2'd1;
  localparam mode_t MODE_DELETE     = 2'd2;
  localparam mode_t MODE_DUMP       = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic compare;
    logic exec;
    logic dump_step;
  } oli_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic dump_last;
  } oli_sts_t;

endpackage

// ===== rtl/oli_datapath.sv =====
module oli_datapath import oli_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  oli_cmd_t                   cmd_i,
  output oli_sts_t                   sts_o,
  input  mode_t                      in_mode,
  input  logic signed [VALUE_W-1:0]  in_value,
  output status_t                    out_status,
  output logic signed [VALUE_W-1:0]  out_element,
  output logic [LENGTH_W-1:0]        out_length,
  output logic                       out_last
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [VALUE_W-1:0]  cells_r   [CAPACITY];
  logic [VALUE_W-1:0]  cells_nxt [CAPACITY];
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  mode_t               mode_r;
  logic [VALUE_W-1:0]  val_r;
  logic [CAPACITY-1:0] eq_w;
  logic [CAPACITY-1:0] hit_w;
  logic [CAPACITY-1:0] hit_r;

  status_t             out_status_r;
  logic [VALUE_W-1:0]  out_element_r;
  logic [LENGTH_W-1:0] out_length_r;
  logic                out_last_r;

  logic    full_w, empty_w, found_w;
  logic    push_ok, front_go, back_go, del_go, rot_go;
  status_t res_status;

  assign full_w  = (count_r == CW'(CAPACITY));
  assign empty_w = (count_r == '0);
  assign found_w = |hit_r;

  assign push_ok  = cmd_i.exec && !full_w &&
                    (mode_r == MODE_PUSH_FRONT || mode_r == MODE_PUSH_BACK);
  assign front_go = push_ok && (mode_r == MODE_PUSH_FRONT);
  assign back_go  = push_ok && (mode_r == MODE_PUSH_BACK);
  assign del_go   = cmd_i.exec && (mode_r == MODE_DELETE) && found_w;
  assign rot_go   = cmd_i.dump_step;

  assign sts_o.empty     = empty_w;
  assign sts_o.dump_last = (rem_r == CW'(1));

  // one cell per entry: compare, then shift toward front or back in parallel
  for (genvar g = 0; g < CAPACITY; g++) begin : gen_cell
    logic [VALUE_W-1:0] prev_w;
    logic [VALUE_W-1:0] next_w;
    logic [VALUE_W-1:0] nxt_w;
    logic               at_tail;
    logic               at_back;

    if (g == 0) begin : gen_head
      assign prev_w = val_r;
    end else begin : gen_body
      assign prev_w = cells_r[g-1];
    end

    if (g == CAPACITY - 1) begin : gen_end
      assign next_w = cells_r[0];
    end else begin : gen_inner
      assign next_w = cells_r[g+1];
    end

    assign at_tail  = (CW'(g + 1) == count_r);
    assign at_back  = (CW'(g) == count_r);
    assign eq_w[g]  = (cells_r[g] == val_r) && (CW'(g) < count_r);
    // at or after the first match
    assign hit_w[g] = |eq_w[g:0];

    always_comb begin
      nxt_w = cells_r[g];
      if (front_go) begin
        nxt_w = prev_w;
      end else if (back_go && at_back) begin
        nxt_w = val_r;
      end else if (del_go && hit_r[g]) begin
        nxt_w = next_w;
      end else if (rot_go) begin
        // rotate the used part by one so the head walks through the list
        nxt_w = at_tail ? cells_r[0] : next_w;
      end
    end

    assign cells_nxt[g] = nxt_w;
  end

  always_comb begin
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (del_go) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    if (cmd_i.latch) begin
      rem_nxt = count_r;
    end else if (cmd_i.dump_step) begin
      rem_nxt = rem_r - CW'(1);
    end
  end

  always_comb begin
    case (mode_r)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        res_status = full_w ? ST_FULL : ST_OK;
      end
      MODE_DELETE: begin
        if (empty_w) begin
          res_status = ST_EMPTY;
        end else begin
          res_status = found_w ? ST_OK : ST_NOTFOUND;
        end
      end
      default: begin
        res_status = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rem_r   <= '0;
    end else begin
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
    if (cmd_i.latch) begin
      mode_r <= in_mode;
      val_r  <= in_value;
    end
    if (cmd_i.compare) begin
      hit_r <= hit_w;
    end
    if (cmd_i.exec) begin
      out_status_r  <= res_status;
      out_element_r <= '0;
      out_length_r  <= LENGTH_W'(count_nxt);
      out_last_r    <= 1'b1;
    end else if (cmd_i.dump_step) begin
      out_status_r  <= ST_OK;
      out_element_r <= cells_r[0];
      out_length_r  <= LENGTH_W'(count_r);
      out_last_r    <= sts_o.dump_last;
    end
  end

  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_length  = out_length_r;
  assign out_last    = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list count above capacity");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.dump_step |-> !empty_w)
    else $error("dump step on empty list");

  a_exec_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.exec |=> out_last_r)
    else $error("single result without last marker");

endmodule

// ===== rtl/oli_ctrl.sv =====
module oli_ctrl import oli_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mode_t    in_mode,
  output logic     out_valid,
  input  logic     out_ready,
  output oli_cmd_t cmd_o,
  input  oli_sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC,
    S_DUMP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_o         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.latch = 1'b1;
          if (in_mode == MODE_DELETE) begin
            state_nxt = S_CMP;
          end else if (in_mode == MODE_DUMP && !sts_i.empty) begin
            state_nxt = S_DUMP;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_CMP: begin
        cmd_o.compare = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd_o.dump_step = 1'b1;
          out_valid_nxt   = 1'b1;
          if (sts_i.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_cmp_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |=> state_r == S_EXEC)
    else $error("compare not followed by execute");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.exec || cmd_o.dump_step |-> !out_valid_r || out_ready)
    else $error("result register overwritten before transaction");

endmodule

// ===== rtl/ordered_list_insert_delete.sv =====
// Bounded ordered list of signed 32-bit values, up to CAPACITY entries, kept in a row of
// register cells that compare and shift in parallel. After a transaction is accepted on
// the input, push front and push back go on to a shift or write into the cells, delete
// first compares the value against every cell and then closes the gap, and dump sends
// the head cell out each cycle unless the output stalls, while the used part of the row
// rotates by one, so the list is back in order at the end; a dump of an empty list goes
// straight to a single result. Results go through an output register, so a stalled
// output only holds the block when the next result is ready to be loaded; in_ready is
// high whenever no operation is in progress. Entries past the current length are never
// read and need no clearing after reset.
module ordered_list_insert_delete import oli_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_mode,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic signed [VALUE_W-1:0] out_element,
  output logic [LENGTH_W-1:0]       out_length,
  output logic                      out_last
);

  oli_cmd_t cmd;
  oli_sts_t sts;

  oli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  oli_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_mode     (in_mode),
    .in_value    (in_value),
    .out_status  (out_status),
    .out_element (out_element),
    .out_length  (out_length),
    .out_last    (out_last)
  );

endmodule

// ===== sim/ordered_list_insert_delete_tb.sv =====
module ordered_list_insert_delete_tb;
  import oli_pkg::*;

  localparam int LIST_CAP   = 16;
  localparam int DRAIN_WAIT = LIST_CAP + 8;
  localparam int LONG_HOLD  = 300;
  localparam int MAX_GAP    = 20;
  localparam int RUN_LIMIT  = 10_000_000;

  typedef struct {
    status_t                   status;
    logic signed [VALUE_W-1:0] element;
    logic [LENGTH_W-1:0]       length;
    logic                      last;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  mode_t                     in_mode = MODE_PUSH_FRONT;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  status_t                   out_status;
  logic signed [VALUE_W-1:0] out_element;
  logic [LENGTH_W-1:0]       out_length;
  logic                      out_last;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic holding = 1'b0;
  event hold_ev;
  int   fail_count = 0;

  logic signed [VALUE_W-1:0] shadow_list[$];
  list_result_t              pending_results[$];

  ordered_list_insert_delete #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_element(out_element),
    .out_length (out_length),
    .out_last   (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void queue_result(status_t st, logic signed [VALUE_W-1:0] el,
                                       logic lst);
    list_result_t r;
    r.status  = st;
    r.element = el;
    r.length  = LENGTH_W'(shadow_list.size());
    r.last    = lst;
    pending_results.push_back(r);
  endfunction

  // updates the shadow list and queues the results of one accepted transaction
  function automatic void apply_list_op(mode_t m, logic signed [VALUE_W-1:0] v);
    int hit;
    hit = -1;
    case (m)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (shadow_list.size() >= LIST_CAP) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          if (m == MODE_PUSH_FRONT) shadow_list.push_front(v);
          else shadow_list.push_back(v);
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      MODE_DELETE: begin
        if (shadow_list.size() == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          foreach (shadow_list[i]) if (hit < 0 && shadow_list[i] == v) hit = i;
          if (hit < 0) begin
            queue_result(ST_NOTFOUND, '0, 1'b1);
          end else begin
            shadow_list.delete(hit);
            queue_result(ST_OK, '0, 1'b1);
          end
        end
      end
      default: begin
        if (shadow_list.size() == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_list.size(); i++)
            queue_result(ST_OK, shadow_list[i], i == shadow_list.size() - 1);
        end
      end
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh80000000;
      1: return 32'sh7FFFFFFF;
      // narrow range so duplicates show up
      2, 3, 4: return $signed(VALUE_W'($urandom_range(6))) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] delete_value();
    if (shadow_list.size() != 0 && $urandom_range(3) != 0)
      return shadow_list[$urandom_range(shadow_list.size() - 1)];
    return pick_value();
  endfunction

  task automatic send_op(mode_t m, logic signed [VALUE_W-1:0] v);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    apply_list_op(m, v);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic send_random_op();
    int r;
    int push_pct;
    r = $urandom_range(99);
    push_pct = (shadow_list.size() > 12) ? 35 : 55;
    if (r < push_pct)
      send_op($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value());
    else if (r < push_pct + 30)
      send_op(MODE_DELETE, delete_value());
    else
      send_op(MODE_DUMP, $urandom);
  endtask

  // delete every entry in random order, then dump the empty list
  task automatic clear_list();
    logic signed [VALUE_W-1:0] left[$];
    int k;
    left = shadow_list;
    while (left.size() != 0) begin
      k = $urandom_range(left.size() - 1);
      send_op(MODE_DELETE, left[k]);
      left.delete(k);
    end
    send_op(MODE_DUMP, $urandom);
  endtask

  task automatic test_directed_ops();
    send_op(MODE_DUMP, '1);
    send_op(MODE_DELETE, '0);
    send_op(MODE_PUSH_BACK, 32'sh7FFFFFFF);
    send_op(MODE_PUSH_FRONT, 32'sh80000000);
    send_op(MODE_PUSH_BACK, '0);
    send_op(MODE_PUSH_BACK, -32'sd1);
    send_op(MODE_PUSH_BACK, 32'sd5);
    send_op(MODE_PUSH_FRONT, 32'sd5);
    send_op(MODE_DUMP, '0);
    // two matches: only the front one goes
    send_op(MODE_DELETE, 32'sd5);
    send_op(MODE_DELETE, 32'sd123);
    send_op(MODE_DELETE, -32'sd1);
    send_op(MODE_DELETE, 32'sh7FFFFFFF);
    send_op(MODE_DUMP, '0);
    wait_drained();
  endtask

  task automatic test_fill_to_capacity();
    while (shadow_list.size() < LIST_CAP)
      send_op($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value());
    send_op(MODE_PUSH_FRONT, pick_value());
    send_op(MODE_PUSH_BACK, pick_value());
    send_op(MODE_DUMP, '0);
    send_op(MODE_DELETE, shadow_list[LIST_CAP-1]);
    send_op(MODE_PUSH_BACK, pick_value());
    send_op(MODE_DUMP, '1);
    clear_list();
    wait_drained();
  endtask

  task automatic test_random_mix(int idle_pct, int stall_pct, int n_ops);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_ops) begin
      if ($urandom_range(39) == 0) clear_list();
      else send_random_op();
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_ev;
    repeat (40) send_random_op();
    wait_drained();
  endtask

  // long receiver hold-off, counted here so the sender keeps pushing
  initial forever begin
    @(hold_ev);
    holding <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: status %0d element %0d", out_status, out_element);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_element !== want.element) begin
          $error("element: expected %0d, got %0d", want.element, out_element);
          fail_count++;
        end
        if (out_length !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, out_length);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_fill_to_capacity();
    test_random_mix(0, 0, 75);
    test_random_mix(58, 0, 75);
    test_random_mix(0, 58, 75);
    test_random_mix(24, 24, 75);
    test_backpressure();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/oli_pkg.sv
rtl/oli_datapath.sv
rtl/oli_ctrl.sv
rtl/ordered_list_insert_delete.sv
sim/ordered_list_insert_delete_tb.sv
